// ===== hdl/kwm_pkg.sv =====
package kwm_pkg;

  localparam int LISTS_DEFAULT      = 8;
  localparam int LENGTH_DEFAULT     = 64;
  localparam int VALUE_BITS_DEFAULT = 32;

  localparam int MODE_BITS   = 1;
  localparam int INDEX_BITS  = 3;
  localparam int DATA_BITS   = 32;
  localparam int STATUS_BITS = 2;

  localparam int COUNT_BITS  = 4;
  localparam int LENGTH_BITS = 7;

  localparam int CFG_INDEX_BITS = 4;
  localparam int CFG_DATA_BITS  = 32;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_LIST_COUNT  = 4'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_LIST_LENGTH = 4'd1;

  localparam logic [COUNT_BITS-1:0]  LIST_COUNT_RESET  = 4'd8;
  localparam logic [LENGTH_BITS-1:0] LIST_LENGTH_RESET = 7'd64;

  localparam logic [MODE_BITS-1:0] MODE_LOAD  = 1'b0;
  localparam logic [MODE_BITS-1:0] MODE_DRAIN = 1'b1;

  typedef enum logic [STATUS_BITS-1:0] {
    STAT_LOAD_OK  = 2'd0,
    STAT_LOAD_REJ = 2'd1,
    STAT_VALUE    = 2'd2,
    STAT_EMPTY    = 2'd3
  } status_t;

  typedef struct packed {
    logic load;
    logic start;
    logic issue;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic issue_more;
    logic out_free;
  } stat_t;

endpackage

// ===== hdl/kwm_item_if.sv =====
interface kwm_item_if;
  logic                             valid;
  logic                             ready;
  logic [kwm_pkg::MODE_BITS-1:0]    mode;
  logic [kwm_pkg::INDEX_BITS-1:0]   list_index;
  logic signed [kwm_pkg::DATA_BITS-1:0] value;

  modport source (output valid, output mode, output list_index, output value, input ready);
  modport sink (input valid, input mode, input list_index, input value, output ready);
endinterface

// ===== hdl/kwm_result_if.sv =====
interface kwm_result_if;
  logic                                 valid;
  logic                                 ready;
  logic [kwm_pkg::STATUS_BITS-1:0]      status;
  logic signed [kwm_pkg::DATA_BITS-1:0] merged_value;
  logic [kwm_pkg::INDEX_BITS-1:0]       source_list;
  logic                                 last;

  modport source (output valid, output status, output merged_value, output source_list,
                  output last, input ready);
  modport sink (input valid, input status, input merged_value, input source_list,
                input last, output ready);
endinterface

// ===== hdl/kwm_cfg_if.sv =====
interface kwm_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [kwm_pkg::CFG_INDEX_BITS-1:0]  index;
  logic [kwm_pkg::CFG_DATA_BITS-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hdl/k_way_sorted_merge_top.sv =====
// Merges up to LISTS ascending lists of signed values into one ascending stream. A load beat
// (mode 0) appends value to list_index and returns status 0, or 1 when rejected (while draining,
// list at or above list_count or LISTS, or list full). A drain beat (mode 1) returns the smallest
// remaining head with its source list, ties going to the lower list, and marks the final value
// with last; status 3 means nothing is left. After the final value the store is empty again.
// A drain scans the n active lists (n = min of list_count and LISTS): the single read port of
// the value memory fetches one list head per cycle, a compare stage follows it and the answer
// is registered. A new beat is taken only while idle and once the pending answer is taken.
// Lists are not checked for order. The user must write configuration only while idle; the
// block does not enforce it. No clearing pass is needed after reset.
module k_way_sorted_merge_top #(
  parameter int LISTS      = kwm_pkg::LISTS_DEFAULT,
  parameter int LENGTH     = kwm_pkg::LENGTH_DEFAULT,
  parameter int VALUE_BITS = kwm_pkg::VALUE_BITS_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  kwm_item_if.sink     item,
  kwm_result_if.source result,
  kwm_cfg_if.sink      cfg
);

  kwm_pkg::cmd_t  cmd;
  kwm_pkg::stat_t stat;
  logic           ready;

  assign item.ready = ready;

  kwm_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .item_mode  (item.mode),
    .item_ready (ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  kwm_datapath #(
    .LISTS      (LISTS),
    .LENGTH     (LENGTH),
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .result (result),
    .cfg    (cfg),
    .cmd    (cmd),
    .stat   (stat)
  );

endmodule

// ===== hdl/kwm_ctrl.sv =====
module kwm_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  input  logic [kwm_pkg::MODE_BITS-1:0] item_mode,
  output logic                          item_ready,
  input  kwm_pkg::stat_t                stat,
  output kwm_pkg::cmd_t                 cmd
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign item_ready = (state == ST_IDLE) && stat.out_free;
  assign accept     = item_valid && item_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (item_mode == kwm_pkg::MODE_DRAIN) begin
            cmd.start  = 1'b1;
            state_next = ST_SCAN;
          end else begin
            cmd.load = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        if (stat.issue_more) begin
          cmd.issue = 1'b1;
        end else begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        cmd.emit   = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== hdl/kwm_datapath.sv =====
module kwm_datapath #(
  parameter int LISTS      = kwm_pkg::LISTS_DEFAULT,
  parameter int LENGTH     = kwm_pkg::LENGTH_DEFAULT,
  parameter int VALUE_BITS = kwm_pkg::VALUE_BITS_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  kwm_item_if.sink             item,
  kwm_result_if.source         result,
  kwm_cfg_if.sink              cfg,
  input  kwm_pkg::cmd_t        cmd,
  output kwm_pkg::stat_t       stat
);

  localparam int LW = $clog2(LISTS);
  localparam int NW = $clog2(LISTS + 1);
  localparam int CW = $clog2(LENGTH + 1);
  localparam int PW = (LENGTH > 1) ? $clog2(LENGTH) : 1;
  localparam int AW = LW + PW;
  localparam int DEPTH = LISTS * (1 << PW);

  logic [kwm_pkg::COUNT_BITS-1:0]  list_count;
  logic [kwm_pkg::LENGTH_BITS-1:0] list_length;

  logic [CW-1:0] fill_count    [LISTS];
  logic [CW-1:0] read_position [LISTS];
  logic          draining;

  logic signed [VALUE_BITS-1:0] mem [DEPTH];
  logic signed [VALUE_BITS-1:0] rd_data;
  logic [AW-1:0]                rd_addr;
  logic [AW-1:0]                wr_addr;

  logic [NW-1:0] scan_k;
  logic          stage_v;
  logic          stage_ok;
  logic          stage_multi;
  logic [LW-1:0] stage_idx;

  logic                         seen;
  logic                         many;
  logic signed [VALUE_BITS-1:0] best_val;
  logic [LW-1:0]                best_idx;

  logic                                 out_valid;
  kwm_pkg::status_t                     out_status;
  logic signed [kwm_pkg::DATA_BITS-1:0] out_value;
  logic [kwm_pkg::INDEX_BITS-1:0]       out_source;
  logic                                 out_last;

  logic [NW-1:0]                active;
  logic [CW-1:0]                cap;
  logic [LW-1:0]                load_sel;
  logic [LW-1:0]                scan_sel;
  logic                         load_ok;
  logic signed [VALUE_BITS-1:0] value_ext;
  logic                         take;

  assign active = (int'(list_count) < LISTS) ? NW'(list_count) : NW'(LISTS);
  assign cap    = (int'(list_length) < LENGTH) ? CW'(list_length) : CW'(LENGTH);

  assign load_sel  = LW'(item.list_index);
  assign scan_sel  = scan_k[LW-1:0];
  assign value_ext = VALUE_BITS'(item.value);
  assign load_ok   = !draining && (int'(item.list_index) < int'(active)) &&
                     (fill_count[load_sel] < cap);

  assign rd_addr = {scan_sel, read_position[scan_sel][PW-1:0]};
  assign wr_addr = {load_sel, fill_count[load_sel][PW-1:0]};

  assign take            = stage_v && stage_ok && (!seen || (rd_data < best_val));
  assign stat.issue_more = scan_k < active;
  assign stat.out_free   = !out_valid || result.ready;

  assign cfg.ready = 1'b1;

  assign result.valid        = out_valid;
  assign result.status       = out_status;
  assign result.merged_value = out_value;
  assign result.source_list  = out_source;
  assign result.last         = out_last;

  // value store
  always_ff @(posedge clk) begin
    if (cmd.load && load_ok) begin
      mem[wr_addr] <= value_ext;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      list_count  <= kwm_pkg::LIST_COUNT_RESET;
      list_length <= kwm_pkg::LIST_LENGTH_RESET;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        kwm_pkg::CFG_LIST_COUNT:  list_count  <= cfg.data[kwm_pkg::COUNT_BITS-1:0];
        kwm_pkg::CFG_LIST_LENGTH: list_length <= cfg.data[kwm_pkg::LENGTH_BITS-1:0];
        default: ;
      endcase
    end
  end

  // list bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LISTS; i++) begin
        fill_count[i]    <= '0;
        read_position[i] <= '0;
      end
      draining <= 1'b0;
    end else if (cmd.load && load_ok) begin
      fill_count[load_sel] <= fill_count[load_sel] + CW'(1);
    end else if (cmd.emit) begin
      if (!seen || !many) begin
        for (int i = 0; i < LISTS; i++) begin
          fill_count[i]    <= '0;
          read_position[i] <= '0;
        end
        draining <= 1'b0;
      end else begin
        read_position[best_idx] <= read_position[best_idx] + CW'(1);
        draining                <= 1'b1;
      end
    end
  end

  // head scan, one list per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_k  <= '0;
      stage_v <= 1'b0;
    end else begin
      stage_v <= cmd.issue;
      if (cmd.start) begin
        scan_k <= '0;
      end else if (cmd.issue) begin
        scan_k <= scan_k + NW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      stage_idx   <= scan_sel;
      stage_ok    <= read_position[scan_sel] < fill_count[scan_sel];
      stage_multi <= ({1'b0, read_position[scan_sel]} + (CW + 1)'(1)) <
                     {1'b0, fill_count[scan_sel]};
    end
    if (cmd.start) begin
      seen <= 1'b0;
      many <= 1'b0;
    end else if (stage_v && stage_ok) begin
      seen <= 1'b1;
      many <= many || seen || stage_multi;
    end
    if (take) begin
      best_val <= rd_data;
      best_idx <= stage_idx;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load || cmd.emit) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_status <= load_ok ? kwm_pkg::STAT_LOAD_OK : kwm_pkg::STAT_LOAD_REJ;
      out_value  <= '0;
      out_source <= '0;
      out_last   <= 1'b0;
    end else if (cmd.emit) begin
      if (seen) begin
        out_status <= kwm_pkg::STAT_VALUE;
        out_value  <= kwm_pkg::DATA_BITS'(best_val);
        out_source <= kwm_pkg::INDEX_BITS'(best_idx);
        out_last   <= !many;
      end else begin
        out_status <= kwm_pkg::STAT_EMPTY;
        out_value  <= '0;
        out_source <= '0;
        out_last   <= 1'b0;
      end
    end
  end

endmodule
